// File: rtl/core/assert_macros.svh
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is held.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// Next-cycle implication, off while reset is held.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// File: rtl/core/vdsm_pkg.sv
// Types and constants of the vertex distance / seed mean block.
package vdsm_pkg;

    localparam int POS_W             = 32;
    localparam int DIST_W            = 33;
    localparam int RAD_W             = 66;
    localparam int MAX_SEED_VERTICES = 1024;
    localparam int CNT_W             = $clog2(MAX_SEED_VERTICES + 1);
    localparam int SUM_W             = DIST_W + $clog2(MAX_SEED_VERTICES);
    localparam int NUM_COMP          = 4;

    typedef struct packed {
        logic signed [POS_W-1:0] pos_a_x;
        logic signed [POS_W-1:0] pos_a_y;
        logic signed [POS_W-1:0] pos_a_z;
        logic signed [POS_W-1:0] pos_a_w;
        logic signed [POS_W-1:0] pos_b_x;
        logic signed [POS_W-1:0] pos_b_y;
        logic signed [POS_W-1:0] pos_b_z;
        logic signed [POS_W-1:0] pos_b_w;
        logic                    seed_end;
    } t_vertex_in;

    typedef struct packed {
        logic [DIST_W-1:0] dist_value;
        logic              is_seed_mean;
        logic              count_saturated;
    } t_dist_out;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQ,
        S_ROOT,
        S_ACC,
        S_DIV,
        S_EMIT
    } t_state;

endpackage

// File: rtl/core/vdsm_sqrt.sv
// Bit-serial integer square root: one root bit per cycle.
module vdsm_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vdsm_pkg::RAD_W-1:0]  i_radicand,
    output logic                        o_done,
    output logic [vdsm_pkg::DIST_W-1:0] o_root
);
    import vdsm_pkg::*;

    localparam int REM_W  = DIST_W + 1;
    localparam int SH_W   = REM_W + 2;
    localparam int ITER_W = $clog2(DIST_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(DIST_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [RAD_W-1:0]  r_rad,  n_rad;
    logic [REM_W-1:0]  r_rem,  n_rem;
    logic [DIST_W-1:0] r_root, n_root;

    logic [SH_W-1:0] w_rem_sh;
    logic [SH_W-1:0] w_trial;
    logic            w_ge;

    // bring down the next two radicand bits and try root*4+1
    always_comb begin
        w_rem_sh = {r_rem, r_rad[RAD_W-1 -: 2]};
        w_trial  = {1'b0, r_root, 2'b01};
        w_ge     = (w_rem_sh >= w_trial);
    end

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_rad  = r_rad;
        n_rem  = r_rem;
        n_root = r_root;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_rad  = i_radicand;
            n_rem  = '0;
            n_root = '0;
        end else if (r_busy) begin
            n_rad  = {r_rad[RAD_W-3:0], 2'b00};
            n_rem  = w_ge ? REM_W'(w_rem_sh - w_trial) : REM_W'(w_rem_sh);
            n_root = {r_root[DIST_W-2:0], w_ge};
            n_iter = r_iter + 1'b1;
            if (r_iter == ITER_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad  <= n_rad;
        r_rem  <= n_rem;
        r_root <= n_root;
    end

    assign o_done = r_done;
    assign o_root = r_root;

endmodule

// File: rtl/core/vdsm_div.sv
// Bit-serial restoring divider for the seed mean: one quotient bit per cycle.
module vdsm_div (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [vdsm_pkg::SUM_W-1:0] i_dividend,
    input  logic [vdsm_pkg::CNT_W-1:0] i_divisor,
    output logic                       o_done,
    output logic [vdsm_pkg::SUM_W-1:0] o_quot
);
    import vdsm_pkg::*;

    localparam int ITER_W = $clog2(SUM_W);
    localparam logic [ITER_W-1:0] ITER_LAST = ITER_W'(SUM_W - 1);

    logic              r_busy, n_busy;
    logic              r_done, n_done;
    logic [ITER_W-1:0] r_iter, n_iter;
    logic [SUM_W-1:0]  r_dvd,  n_dvd;
    logic [CNT_W-1:0]  r_dvs,  n_dvs;
    logic [CNT_W-1:0]  r_rem,  n_rem;

    logic [CNT_W:0] w_rem_sh;
    logic [CNT_W:0] w_dvs_ext;
    logic           w_ge;

    always_comb begin
        w_rem_sh  = {r_rem, r_dvd[SUM_W-1]};
        w_dvs_ext = {1'b0, r_dvs};
        w_ge      = (w_rem_sh >= w_dvs_ext);
    end

    // dividend shifts out at the top while quotient bits enter at the bottom
    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_iter = r_iter;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_rem  = r_rem;
        if (i_start) begin
            n_busy = 1'b1;
            n_iter = '0;
            n_dvd  = i_dividend;
            n_dvs  = i_divisor;
            n_rem  = '0;
        end else if (r_busy) begin
            n_rem  = w_ge ? CNT_W'(w_rem_sh - w_dvs_ext) : CNT_W'(w_rem_sh);
            n_dvd  = {r_dvd[SUM_W-2:0], w_ge};
            n_iter = r_iter + 1'b1;
            if (r_iter == ITER_LAST) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_iter <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_iter <= n_iter;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
        r_rem <= n_rem;
    end

    assign o_done = r_done;
    assign o_quot = r_dvd;

endmodule

// File: rtl/core/vertex_distance_seed_mean.sv
// Top level: 4D vertex distance with optional per-seed mean.
//
// Input channel (i_in_valid / o_in_ready, payload i_in) takes one vertex pair
// per beat: two signed Q16.16 4D positions and a seed_end mark. Output channel
// (o_out_valid / i_out_ready, payload o_out) returns the floored Q17.16
// distance, or in per-seed mode the floored mean over the seed.
// Config channel (i_cfg_valid / o_cfg_ready, i_cfg_data) writes output_mode;
// write it only while the block is idle. It is always ready.
// Work on one beat: component differences and squares through a single 32x32
// multiplier, then the bit-serial square root (one root bit per cycle). A
// vertex-mode result is then loaded into the output register, and the next
// beat is taken after that. In per-seed mode a vertex that is not the seed's
// last yields no beat; the last one also passes through the bit-serial divider
// (one quotient bit per cycle over the 43-bit sum). The block handles one beat
// at a time.
// Reset clears the mode, the seed accumulators and the output valid.
// A stalled receiver holds the result in the output register; the next beat
// is still computed and waits until the output register frees up.
module vertex_distance_seed_mean (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  vdsm_pkg::t_vertex_in  i_in,
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output vdsm_pkg::t_dist_out   o_out,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic                  i_cfg_data
);
    import vdsm_pkg::*;

    `include "assert_macros.svh"

    localparam int VEC_W = POS_W * NUM_COMP;
    localparam int SQ_W  = 2 * POS_W;
    localparam logic [2:0] SQ_LAST = 3'(NUM_COMP + 2);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_SEED_VERTICES);

    t_state r_state, n_state;

    logic r_mode;
    logic r_out_valid;
    t_dist_out r_out;
    t_dist_out r_res;

    logic [2:0]        r_sq_cnt;
    logic [VEC_W-1:0]  r_pa;
    logic [VEC_W-1:0]  r_pb;
    logic [POS_W-1:0]  r_diff;
    logic [SQ_W-1:0]   r_sq;
    logic [RAD_W-1:0]  r_rad;
    logic              r_seed_end;

    logic [SUM_W-1:0]  r_sum, n_sum;
    logic [CNT_W-1:0]  r_count, n_count;
    logic              r_sat, n_sat;

    // FSM controls
    logic w_accept;
    logic w_sq_en;
    logic w_root_start;
    logic w_acc_en;
    logic w_div_start;
    logic w_vertex_res;
    logic w_out_load;

    logic              w_root_done;
    logic [DIST_W-1:0] w_root;
    logic              w_div_done;
    logic [SUM_W-1:0]  w_quot;

    logic signed [POS_W:0] w_sdiff;

    assign o_cfg_ready = 1'b1;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) n_state = S_SQ;
            end
            S_SQ: begin
                if (r_sq_cnt == SQ_LAST) n_state = S_ROOT;
            end
            S_ROOT: begin
                if (w_root_done) n_state = r_mode ? S_ACC : S_EMIT;
            end
            S_ACC: begin
                n_state = r_seed_end ? S_DIV : S_IDLE;
            end
            S_DIV: begin
                if (w_div_done) n_state = S_EMIT;
            end
            S_EMIT: begin
                if (!r_out_valid || i_out_ready) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    // FSM outputs
    always_comb begin
        o_in_ready   = 1'b0;
        w_sq_en      = 1'b0;
        w_root_start = 1'b0;
        w_acc_en     = 1'b0;
        w_div_start  = 1'b0;
        w_vertex_res = 1'b0;
        w_out_load   = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
            end
            S_SQ: begin
                w_sq_en      = 1'b1;
                w_root_start = (r_sq_cnt == SQ_LAST);
            end
            S_ROOT: begin
                w_vertex_res = w_root_done && !r_mode;
            end
            S_ACC: begin
                w_acc_en    = 1'b1;
                w_div_start = r_seed_end;
            end
            S_EMIT: begin
                w_out_load = !r_out_valid || i_out_ready;
            end
            default: begin
                o_in_ready = 1'b0;
            end
        endcase
    end

    assign w_accept = i_in_valid && o_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_mode      <= 1'b0;
            r_out_valid <= 1'b0;
            r_sq_cnt    <= '0;
            r_sum       <= '0;
            r_count     <= '0;
            r_sat       <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid) r_mode <= i_cfg_data;
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (w_accept) begin
                r_sq_cnt <= '0;
            end else if (w_sq_en) begin
                r_sq_cnt <= r_sq_cnt + 1'b1;
            end
            r_sum   <= n_sum;
            r_count <= n_count;
            r_sat   <= n_sat;
        end
    end

    // one component per cycle: difference, square, accumulate
    assign w_sdiff = {r_pa[POS_W-1], r_pa[POS_W-1:0]} - {r_pb[POS_W-1], r_pb[POS_W-1:0]};

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_pa       <= {i_in.pos_a_w, i_in.pos_a_z, i_in.pos_a_y, i_in.pos_a_x};
            r_pb       <= {i_in.pos_b_w, i_in.pos_b_z, i_in.pos_b_y, i_in.pos_b_x};
            r_seed_end <= i_in.seed_end;
            r_diff     <= '0;
            r_sq       <= '0;
            r_rad      <= '0;
        end else if (w_sq_en) begin
            r_pa   <= {{POS_W{1'b0}}, r_pa[VEC_W-1:POS_W]};
            r_pb   <= {{POS_W{1'b0}}, r_pb[VEC_W-1:POS_W]};
            r_diff <= w_sdiff[POS_W] ? POS_W'(-w_sdiff) : POS_W'(w_sdiff);
            r_sq   <= r_diff * r_diff;
            r_rad  <= r_rad + RAD_W'(r_sq);
        end
    end

    // seed accumulation; the last vertex is added before the mean is taken
    always_comb begin
        n_sum   = r_sum;
        n_count = r_count;
        n_sat   = r_sat;
        if (w_acc_en) begin
            if (r_count < CNT_MAX) begin
                n_sum   = r_sum + SUM_W'(w_root);
                n_count = r_count + 1'b1;
            end else begin
                n_sat = 1'b1;
            end
            if (r_seed_end) begin
                n_sum   = '0;
                n_count = '0;
                n_sat   = 1'b0;
            end
        end
    end

    logic [SUM_W-1:0] w_div_dvd;
    logic [CNT_W-1:0] w_div_dvs;

    always_comb begin
        if (r_count < CNT_MAX) begin
            w_div_dvd = r_sum + SUM_W'(w_root);
            w_div_dvs = r_count + 1'b1;
        end else begin
            w_div_dvd = r_sum;
            w_div_dvs = r_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_vertex_res) begin
            r_res.dist_value      <= w_root;
            r_res.is_seed_mean    <= 1'b0;
            r_res.count_saturated <= 1'b0;
        end else if (w_div_start) begin
            r_res.is_seed_mean    <= 1'b1;
            r_res.count_saturated <= (r_count >= CNT_MAX) || r_sat;
        end else if (w_div_done) begin
            r_res.dist_value <= w_quot[DIST_W-1:0];
        end
        if (w_out_load) r_out <= r_res;
    end

    vdsm_sqrt u_sqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_root_start),
        .i_radicand (r_rad),
        .o_done     (w_root_done),
        .o_root     (w_root)
    );

    vdsm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_div_dvd),
        .i_divisor  (w_div_dvs),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    assign o_out_valid = r_out_valid;
    assign o_out       = r_out;

    `ASSERT_IMPL(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_MAX)
    `ASSERT_NEXT(a_accept_to_sq, i_clk, i_rst_n, w_accept, r_state == S_SQ)
    `ASSERT_IMPL(a_root_in_state, i_clk, i_rst_n, w_root_done, r_state == S_ROOT)
    `ASSERT_IMPL(a_div_in_state, i_clk, i_rst_n, w_div_done, r_state == S_DIV)

endmodule

// File: tb/sv/tb_top.sv
`timescale 1ns / 100ps
// Testbench for the 4D vertex distance / seed mean block: predictor, stimulus and result checks.
module tb_top;
    import vdsm_pkg::*;

    localparam int DRAIN_CYCLES = 150;
    localparam int TIMEOUT_NS   = 25_000_000;
    localparam logic [POS_W-1:0] PMAX = 32'h7fff_ffff;
    localparam logic [POS_W-1:0] PMIN = 32'h8000_0000;
    localparam logic [POS_W-1:0] ONE  = 32'h0001_0000;

    typedef enum logic {
        MODE_VERTEX = 1'b0,
        MODE_SEED   = 1'b1
    } t_out_mode;

    // Holds the expected distances / seed means and mirrors the seed accumulators.
    class dist_scoreboard;
        t_out_mode   mode;
        logic [63:0] seed_sum;
        int unsigned seed_count;
        logic        seed_sat;
        t_dist_out   expected_q[$];
        int          errors;

        function new();
            mode       = MODE_VERTEX;
            seed_sum   = '0;
            seed_count = 0;
            seed_sat   = 1'b0;
            errors     = 0;
        endfunction

        function void set_mode(t_out_mode m);
            mode = m;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        // floor(sqrt(sum of squared component differences)), Q17.16
        function logic [DIST_W-1:0] vertex_dist(t_vertex_in v);
            logic signed [POS_W-1:0] a [NUM_COMP];
            logic signed [POS_W-1:0] b [NUM_COMP];
            logic signed [POS_W:0]   d;
            logic signed [POS_W:0]   nd;
            logic [POS_W-1:0]        mag;
            logic [RAD_W-1:0]        rad;
            logic [RAD_W-1:0]        c;
            logic [DIST_W-1:0]       root;
            a = '{v.pos_a_x, v.pos_a_y, v.pos_a_z, v.pos_a_w};
            b = '{v.pos_b_x, v.pos_b_y, v.pos_b_z, v.pos_b_w};
            rad = '0;
            for (int k = 0; k < NUM_COMP; k++) begin
                d   = {a[k][POS_W-1], a[k]} - {b[k][POS_W-1], b[k]};
                nd  = -d;
                mag = d[POS_W] ? nd[POS_W-1:0] : d[POS_W-1:0];
                rad += RAD_W'(mag) * RAD_W'(mag);
            end
            root = '0;
            for (int bit_i = DIST_W - 1; bit_i >= 0; bit_i--) begin
                c = RAD_W'(root | (DIST_W'(1) << bit_i));
                if (c * c <= rad) begin
                    root = c[DIST_W-1:0];
                end
            end
            return root;
        endfunction

        function void note_vertex(t_vertex_in v);
            logic [DIST_W-1:0] vdist;
            logic [63:0]       mean;
            t_dist_out         res;
            vdist = vertex_dist(v);
            if (mode == MODE_VERTEX) begin
                res.dist_value      = vdist;
                res.is_seed_mean    = 1'b0;
                res.count_saturated = 1'b0;
                expected_q.push_back(res);
            end else begin
                // a full count drops further vertices and only marks the seed
                if (seed_count < MAX_SEED_VERTICES) begin
                    seed_sum += 64'(vdist);
                    seed_count++;
                end else begin
                    seed_sat = 1'b1;
                end
                if (v.seed_end) begin
                    mean                = seed_sum / 64'(seed_count);
                    res.dist_value      = mean[DIST_W-1:0];
                    res.is_seed_mean    = 1'b1;
                    res.count_saturated = seed_sat;
                    expected_q.push_back(res);
                    seed_sum   = '0;
                    seed_count = 0;
                    seed_sat   = 1'b0;
                end
            end
        endfunction

        task report_mismatch(string what);
            if (errors < 100) begin
                $display("%0t mismatch: %s", $time, what);
            end
            errors++;
        endtask

        task check_result(t_dist_out got);
            t_dist_out want;
            if (expected_q.size() == 0) begin
                report_mismatch($sformatf("unexpected beat dist=%h mean=%b sat=%b",
                                          got.dist_value, got.is_seed_mean,
                                          got.count_saturated));
            end else begin
                want = expected_q.pop_front();
                if (got.dist_value !== want.dist_value) begin
                    report_mismatch($sformatf("dist_value got %h want %h",
                                              got.dist_value, want.dist_value));
                end
                if (got.is_seed_mean !== want.is_seed_mean) begin
                    report_mismatch($sformatf("is_seed_mean got %b want %b",
                                              got.is_seed_mean, want.is_seed_mean));
                end
                if (got.count_saturated !== want.count_saturated) begin
                    report_mismatch($sformatf("count_saturated got %b want %b",
                                              got.count_saturated, want.count_saturated));
                end
            end
        endtask
    endclass

    logic       i_clk       = 1'b0;
    logic       i_rst_n     = 1'b0;
    logic       i_in_valid  = 1'b0;
    t_vertex_in i_in        = '0;
    logic       i_out_ready = 1'b0;
    logic       i_cfg_valid = 1'b0;
    logic       i_cfg_data  = 1'b0;
    logic       o_in_ready;
    logic       o_out_valid;
    t_dist_out  o_out;
    logic       o_cfg_ready;

    dist_scoreboard sb = new();
    int             in_burst = 0;

    vertex_distance_seed_mean uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in        (i_in),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out       (o_out),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mostly short gaps, a few long ones
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) begin
            gap_len = 0;
        end else if (r < 85) begin
            gap_len = $urandom_range(1, 3);
        end else if (r < 97) begin
            gap_len = $urandom_range(4, 12);
        end else begin
            gap_len = $urandom_range(20, 60);
        end
    endfunction

    function automatic logic [POS_W-1:0] corner_coord();
        case ($urandom_range(0, 3))
            0: corner_coord = PMAX;
            1: corner_coord = PMIN;
            2: corner_coord = '0;
            default: corner_coord = '1;
        endcase
    endfunction

    function automatic t_vertex_in make_vertex(
        input logic [POS_W-1:0] ax, ay, az, aw, bx, by, bz, bw,
        input logic se
    );
        t_vertex_in v;
        v.pos_a_x  = ax;
        v.pos_a_y  = ay;
        v.pos_a_z  = az;
        v.pos_a_w  = aw;
        v.pos_b_x  = bx;
        v.pos_b_y  = by;
        v.pos_b_z  = bz;
        v.pos_b_w  = bw;
        v.seed_end = se;
        return v;
    endfunction

    function automatic t_vertex_in rand_vertex(input logic se);
        logic [POS_W-1:0] a [NUM_COMP];
        logic [POS_W-1:0] b [NUM_COMP];
        int               style;
        style = $urandom_range(0, 9);
        for (int k = 0; k < NUM_COMP; k++) begin
            a[k] = $urandom();
            case (style)
                0: begin
                    a[k] = corner_coord();
                    b[k] = corner_coord();
                end
                1, 2, 3, 4: b[k] = $urandom();
                // nearby points: differences of at most one unit
                5, 6, 7: b[k] = a[k] + $urandom_range(0, 1 << 17) - (1 << 16);
                default: begin
                    a[k] = $urandom_range(0, 1 << 21) - (1 << 20);
                    b[k] = $urandom_range(0, 1 << 21) - (1 << 20);
                end
            endcase
        end
        return make_vertex(a[0], a[1], a[2], a[3], b[0], b[1], b[2], b[3], se);
    endfunction

    task automatic send_vertex(input t_vertex_in v);
        int gap;
        if (in_burst > 0) begin
            in_burst--;
            gap = 0;
        end else begin
            if ($urandom_range(0, 29) == 0) begin
                in_burst = $urandom_range(10, 40);
            end
            gap = gap_len();
        end
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in       = v;
        i_in_valid = 1'b1;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_vertex(v);
    endtask

    // mode writes only once the block has gone quiet
    task automatic write_mode(input t_out_mode m);
        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid = 1'b1;
        i_cfg_data  = m;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.set_mode(m);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // receiver: random stalls with stretches of steady ready
    initial begin : out_side
        int stall;
        int burst;
        stall = 0;
        burst = 0;
        forever begin
            @(negedge i_clk);
            if (burst > 0) begin
                burst--;
                i_out_ready = 1'b1;
            end else if (stall > 0) begin
                stall--;
                i_out_ready = 1'b0;
            end else begin
                if ($urandom_range(0, 29) == 0) begin
                    burst = $urandom_range(10, 60);
                end
                stall = gap_len();
                i_out_ready = (stall == 0);
                if (stall > 0) begin
                    stall--;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            sb.check_result(o_out);
        end
    end

    initial begin
        #(TIMEOUT_NS);
        $display("tb_top: FAIL");
        $finish;
    end

    initial begin : stimulus
        int         seed_left;
        int         r;
        logic       se;
        t_out_mode  m;
        seed_left = 0;
        i_rst_n = 1'b0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // per-vertex mode: extremes; seed_end has no effect here
        write_mode(MODE_VERTEX);
        send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_vertex(make_vertex(PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, 1'b0));
        send_vertex(make_vertex(PMIN, PMIN, PMIN, PMIN, PMAX, PMAX, PMAX, PMAX, 1'b1));
        send_vertex(make_vertex(PMAX, PMIN, PMAX, PMIN, PMIN, PMAX, PMIN, PMAX, 1'b1));
        send_vertex(make_vertex(1, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_vertex(make_vertex(0, 0, 0, PMIN, 0, 0, 0, PMAX, 1'b1));
        send_vertex(make_vertex('1, '1, '1, '1, 0, 0, 0, 0, 1'b0));
        send_vertex(make_vertex(ONE, 2 * ONE, 3 * ONE, 4 * ONE, 0, 0, 0, 0, 1'b0));
        send_vertex(make_vertex(PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, PMAX, 1'b1));

        // per-seed mode: one-vertex seed at the largest distance, then a short seed
        write_mode(MODE_SEED);
        send_vertex(make_vertex(PMAX, PMAX, PMAX, PMAX, PMIN, PMIN, PMIN, PMIN, 1'b1));
        send_vertex(rand_vertex(1'b0));
        send_vertex(make_vertex(0, 0, 0, 0, 0, 0, 0, 0, 1'b0));
        send_vertex(rand_vertex(1'b1));

        // partial seed survives a trip through vertex mode
        send_vertex(rand_vertex(1'b0));
        send_vertex(rand_vertex(1'b0));
        write_mode(MODE_VERTEX);
        send_vertex(rand_vertex(1'b1));
        send_vertex(rand_vertex(1'b0));
        write_mode(MODE_SEED);
        send_vertex(rand_vertex(1'b1));

        // random phases, alternating modes
        for (int ph = 0; ph < 6; ph++) begin
            m = ph[0] ? MODE_SEED : MODE_VERTEX;
            write_mode(m);
            for (int n = 0; n < 67; n++) begin
                if (m == MODE_VERTEX) begin
                    se = $urandom_range(0, 1);
                end else begin
                    if (seed_left == 0) begin
                        r = $urandom_range(0, 99);
                        seed_left = (r < 80) ? $urandom_range(1, 6) : $urandom_range(7, 40);
                    end
                    seed_left--;
                    se = (seed_left == 0);
                    // occasional broken seed: stray or missing end mark
                    if ($urandom_range(0, 19) == 0) begin
                        se = $urandom_range(0, 1);
                        if (se) begin
                            seed_left = 0;
                        end
                    end
                end
                send_vertex(rand_vertex(se));
            end
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule

// File: vertex_distance_seed_mean.f
+incdir+rtl/core
rtl/core/vdsm_pkg.sv
rtl/core/vdsm_sqrt.sv
rtl/core/vdsm_div.sv
rtl/core/vertex_distance_seed_mean.sv
tb/sv/tb_top.sv
